// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers for the SHA-256 hasher
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// assert that a implies b on the same clock edge
`define ASSERT_IMPL(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed");
// assert that a implies b on the next clock edge
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");
`endif

// ===== hw/rtl/sha_pkg.sv =====
// ----------------------------------------------------------------------------
// sha_pkg
// Constants, types and round functions for the SHA-256 hasher.
// ----------------------------------------------------------------------------
`default_nettype none
package sha_pkg;
	localparam int WordW = 32;
	localparam int BlockBytes = 64;
	localparam int LenPos = 56;
	localparam logic [7:0] PadByte = 8'h80;

	typedef logic [WordW-1:0] word_t;

	localparam word_t IV [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

	localparam word_t K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

	// control from sequencer to round unit
	typedef struct packed {
		logic       load;   // copy chain value into working vars
		logic       round;  // run one round
		logic       finish; // add working vars into chain value
		logic       init;   // restore initial hash
		logic [5:0] rnd;    // round number
	} rnd_ctl_t;

	function automatic word_t rotr(word_t x, int n);
		return (x >> n) | (x << (WordW - n));
	endfunction

	function automatic word_t ssig0(word_t x);
		return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic word_t ssig1(word_t x);
		return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

	function automatic word_t bsig0(word_t x);
		return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic word_t bsig1(word_t x);
		return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/sha_round.sv =====
// ----------------------------------------------------------------------------
// sha_round
// Shared round unit: working variables, schedule window and chain value.
// One round per cycle under ctl.round; rounds 0-15 shift in sequencer words.
// ----------------------------------------------------------------------------
`default_nettype none
module sha_round import sha_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire rnd_ctl_t ctl,
	input  wire word_t    msg_word,
	input  wire logic [2:0] rd_idx,
	output word_t         rd_word
);
	word_t v_q [8];
	word_t w_q [16];
	word_t h_q [8];
	word_t w_cur, t1, t2, w_new;

	assign w_new = ssig1(w_q[14]) + w_q[9] + ssig0(w_q[1]) + w_q[0];
	assign w_cur = (ctl.rnd < 6'd16) ? msg_word : w_new;
	assign t1 = v_q[7] + bsig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
		+ K[ctl.rnd] + w_cur;
	assign t2 = bsig0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
	assign rd_word = h_q[rd_idx];

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
		end else if (ctl.round) begin
			v_q[0] <= t1 + t2;
			v_q[1] <= v_q[0];
			v_q[2] <= v_q[1];
			v_q[3] <= v_q[2];
			v_q[4] <= v_q[3] + t1;
			v_q[5] <= v_q[4];
			v_q[6] <= v_q[5];
			v_q[7] <= v_q[6];
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= w_cur;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) h_q[i] <= IV[i];
		end else if (ctl.init) begin
			for (int i = 0; i < 8; i++) h_q[i] <= IV[i];
		end else if (ctl.finish) begin
			for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/sha256_message_hasher_top.sv =====
// ----------------------------------------------------------------------------
// sha256_message_hasher_top
// Byte-serial SHA-256 hasher with padding and digest output.
// ----------------------------------------------------------------------------
// A plain byte request is accepted without stall unless it completes a 64-byte block;
// then the block is compressed by a single shared round unit, one round per
// cycle, and stall stays high through load, 64 rounds and add. A final
// request first writes pad bytes from the 0x80 byte to the end of the block,
// then compresses it; when the length does not fit, a second block of pad
// bytes and another compression follow. The eight digest words, word 0 first,
// are then read straight from the chain value registers, one per cycle while
// the receiver does not stall. The block buffer is a 64x8 memory kept as 16
// word rows written bytewise and read one word per round.
`default_nettype none
`include "assert_macros.svh"
module sha256_message_hasher_top import sha_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  data_byte,
	input  wire logic        byte_present,
	input  wire logic        final_item,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      digest_word,
	output logic [2:0]       word_index,
	output logic             last_word
);
	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_PAD  = 6'b000010,
		S_LOAD = 6'b000100,
		S_RND  = 6'b001000,
		S_ADD  = 6'b010000,
		S_OUT  = 6'b100000
	} state_t;

	state_t     st_q;
	logic [6:0] fill_q;
	logic [63:0] bits_q;
	logic       fin_q;      // final request in progress (padding or compression)
	logic       lendone_q;  // length is placed in the current block
	logic       pad_pend_q; // 0x80 byte still to be written
	logic [5:0] rnd_q;
	logic [2:0] oidx_q;
	logic [31:0] mem [16];
	word_t      rd_q;
	rnd_ctl_t   ctl;
	word_t      hword;

	logic acc, oacc;
	assign acc = in_valid && !in_stall;
	assign oacc = out_valid && !out_stall;
	assign in_stall = (st_q != S_IDLE);

	// pad byte for current fill position
	logic [7:0] pbyte;
	always_comb begin
		pbyte = 8'h00;
		if (fill_q[5:0] >= 6'(LenPos))
			pbyte = bits_q[8*(7-(fill_q[2:0]))+:8];
	end

	// memory: byte writes, word read
	logic       we;
	logic [5:0] wa;
	logic [7:0] wd;
	always_comb begin
		we = 1'b0; wa = fill_q[5:0]; wd = data_byte;
		if (st_q == S_IDLE && acc && byte_present) we = 1'b1;
		else if (st_q == S_PAD) begin
			we = 1'b1;
			if (pad_pend_q) wd = PadByte;
			else wd = lendone_q ? pbyte : 8'h00;
		end
	end

	always_ff @(posedge clk) begin
		if (we) mem[wa[5:2]][8*(3-wa[1:0])+:8] <= wd;
		rd_q <= mem[(st_q == S_LOAD) ? 4'd0 : 4'(rnd_q + 6'd1)];
	end

	assign ctl.load = (st_q == S_LOAD);
	assign ctl.round = (st_q == S_RND);
	assign ctl.finish = (st_q == S_ADD);
	assign ctl.init = oacc && (oidx_q == 3'd7);
	assign ctl.rnd = rnd_q;

	sha_round u_rnd (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .msg_word(rd_q),
		.rd_idx(oidx_q), .rd_word(hword));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE; fill_q <= '0; bits_q <= '0; fin_q <= 1'b0;
			lendone_q <= 1'b0; pad_pend_q <= 1'b0; rnd_q <= '0; oidx_q <= '0;
			out_valid <= 1'b0;
		end else begin
			case (st_q)
				S_IDLE: begin
					if (acc) begin
						if (byte_present) begin
							bits_q <= bits_q + 64'd8;
							if (fill_q == 7'd63) begin
								fill_q <= '0; st_q <= S_LOAD; fin_q <= final_item;
								pad_pend_q <= final_item;
							end else begin
								fill_q <= fill_q + 7'd1;
								if (final_item) begin
									fin_q <= 1'b1; pad_pend_q <= 1'b1; st_q <= S_PAD;
								end
							end
						end else if (final_item) begin
							fin_q <= 1'b1; pad_pend_q <= 1'b1; st_q <= S_PAD;
						end
					end
				end
				S_PAD: begin
					// the length fits only if the pad byte lands before it
					if (pad_pend_q) begin
						pad_pend_q <= 1'b0;
						lendone_q <= (fill_q < 7'(LenPos));
					end
					if (fill_q == 7'd63) begin
						fill_q <= '0; st_q <= S_LOAD;
					end else begin
						fill_q <= fill_q + 7'd1;
					end
				end
				S_LOAD: begin rnd_q <= '0; st_q <= S_RND; end
				S_RND: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) st_q <= S_ADD;
				end
				S_ADD: begin
					if (!fin_q) st_q <= S_IDLE;
					else if (lendone_q) begin
						lendone_q <= 1'b0; fin_q <= 1'b0; oidx_q <= '0;
						out_valid <= 1'b1; st_q <= S_OUT;
					end else begin
						// second pass: pad byte if still pending, zero fill then length
						lendone_q <= 1'b1; st_q <= S_PAD;
					end
				end
				S_OUT: begin
					if (oacc) begin
						oidx_q <= oidx_q + 3'd1;
						if (oidx_q == 3'd7) begin
							out_valid <= 1'b0; st_q <= S_IDLE;
							fill_q <= '0; bits_q <= '0;
						end
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assign digest_word = hword;
	assign word_index = oidx_q;
	assign last_word = (oidx_q == 3'd7);

	`ASSERT_IMPL(a_out_only_in_out, clk, arst_n, out_valid, st_q == S_OUT)
	`ASSERT_IMPL(a_stall_busy, clk, arst_n, st_q == S_RND, in_stall)
	`ASSERT_NEXT(a_rnd_adv, clk, arst_n, st_q == S_RND && rnd_q != 6'd63, st_q == S_RND)
endmodule
`default_nettype wire
